@@ rtl/rvdec_pkg.sv @@
// Shared types and encodings for the RV32I instruction decoder.
// No dependencies; every other file in rtl/ imports this package.
package rvdec_pkg;

  // Major opcodes, instruction bits 6:0
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_IALU   = 7'b0010011;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_R      = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  // Format class
  typedef enum logic [2:0] {
    FMT_UNKNOWN = 3'd0,
    FMT_R       = 3'd1,
    FMT_I       = 3'd2,
    FMT_S       = 3'd3,
    FMT_SB      = 3'd4,
    FMT_U       = 3'd5,
    FMT_UJ      = 3'd6
  } fmt_class_t;

  // Dense operation numbering
  localparam logic [5:0] OP_UNKNOWN = 6'd0;
  localparam logic [5:0] OP_ADD     = 6'd1;
  localparam logic [5:0] OP_SUB     = 6'd2;
  localparam logic [5:0] OP_SLL     = 6'd3;
  localparam logic [5:0] OP_SLT     = 6'd4;
  localparam logic [5:0] OP_SLTU    = 6'd5;
  localparam logic [5:0] OP_XOR     = 6'd6;
  localparam logic [5:0] OP_SRL     = 6'd7;
  localparam logic [5:0] OP_SRA     = 6'd8;
  localparam logic [5:0] OP_OR      = 6'd9;
  localparam logic [5:0] OP_AND     = 6'd10;
  localparam logic [5:0] OP_LB      = 6'd11;
  localparam logic [5:0] OP_LH      = 6'd12;
  localparam logic [5:0] OP_LW      = 6'd13;
  localparam logic [5:0] OP_ADDI    = 6'd14;
  localparam logic [5:0] OP_SLTI    = 6'd15;
  localparam logic [5:0] OP_SLTIU   = 6'd16;
  localparam logic [5:0] OP_XORI    = 6'd17;
  localparam logic [5:0] OP_ORI     = 6'd18;
  localparam logic [5:0] OP_ANDI    = 6'd19;
  localparam logic [5:0] OP_SLLI    = 6'd20;
  localparam logic [5:0] OP_SRLI    = 6'd21;
  localparam logic [5:0] OP_SRAI    = 6'd22;
  localparam logic [5:0] OP_JALR    = 6'd23;
  localparam logic [5:0] OP_SB      = 6'd24;
  localparam logic [5:0] OP_SH      = 6'd25;
  localparam logic [5:0] OP_SW      = 6'd26;
  localparam logic [5:0] OP_BEQ     = 6'd27;
  localparam logic [5:0] OP_BNE     = 6'd28;
  localparam logic [5:0] OP_BLT     = 6'd29;
  localparam logic [5:0] OP_BGE     = 6'd30;
  localparam logic [5:0] OP_LUI     = 6'd31;
  localparam logic [5:0] OP_AUIPC   = 6'd32;
  localparam logic [5:0] OP_JAL     = 6'd33;

  // One decoded instruction
  typedef struct packed {
    logic [6:0]  opcode_field;
    fmt_class_t  format_class;
    logic [5:0]  operation_code;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [2:0]  func3_field;
    logic [6:0]  func7_field;
    logic [31:0] immediate;
  } dec_result_t;

endpackage

@@ rtl/rvdec_core.sv @@
// Combinational RV32I decode: format class, operation number, fields and
// immediate for one instruction word. Depends on rvdec_pkg.
module rvdec_core
  import rvdec_pkg::*;
(
  input  logic [31:0] word,
  output dec_result_t result
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;

  // Slice the raw fields
  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign f7  = word[31:25];

  // Assemble every immediate form in parallel
  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u = {word[31:12], 12'b0};
  assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

  // Classify the opcode and pick the operation
  always_comb begin
    // Raw bit slices pass through whatever the format
    result.opcode_field   = opc;
    result.dest_reg       = word[11:7];
    result.src1_reg       = word[19:15];
    result.src2_reg       = word[24:20];
    result.func3_field    = f3;
    result.func7_field    = f7;
    result.format_class   = FMT_UNKNOWN;
    result.operation_code = OP_UNKNOWN;
    result.immediate      = '0;
    case (opc)
      OPC_R: begin
        result.format_class = FMT_R;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_0:    result.operation_code = OP_ADD;
            F3_1:    result.operation_code = OP_SLL;
            F3_2:    result.operation_code = OP_SLT;
            F3_3:    result.operation_code = OP_SLTU;
            F3_4:    result.operation_code = OP_XOR;
            F3_5:    result.operation_code = OP_SRL;
            F3_6:    result.operation_code = OP_OR;
            default: result.operation_code = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_0) result.operation_code = OP_SUB;
          else if (f3 == F3_5) result.operation_code = OP_SRA;
        end
      end
      OPC_LOAD: begin
        result.format_class = FMT_I;
        result.immediate    = imm_i;
        case (f3)
          F3_0:    result.operation_code = OP_LB;
          F3_1:    result.operation_code = OP_LH;
          F3_2:    result.operation_code = OP_LW;
          default: result.operation_code = OP_UNKNOWN;
        endcase
      end
      OPC_IALU: begin
        result.format_class = FMT_I;
        result.immediate    = imm_i;
        case (f3)
          F3_0: result.operation_code = OP_ADDI;
          F3_2: result.operation_code = OP_SLTI;
          F3_3: result.operation_code = OP_SLTIU;
          F3_4: result.operation_code = OP_XORI;
          F3_6: result.operation_code = OP_ORI;
          F3_7: result.operation_code = OP_ANDI;
          F3_1: result.operation_code = (f7 == F7_BASE) ? OP_SLLI : OP_UNKNOWN;
          default: begin
            // Right shifts: logical or arithmetic by imm[11:5]
            if (f7 == F7_BASE) result.operation_code = OP_SRLI;
            else if (f7 == F7_ALT) result.operation_code = OP_SRAI;
          end
        endcase
      end
      OPC_JALR: begin
        result.format_class   = FMT_I;
        result.immediate      = imm_i;
        result.operation_code = (f3 == F3_0) ? OP_JALR : OP_UNKNOWN;
      end
      OPC_STORE: begin
        result.format_class = FMT_S;
        result.immediate    = imm_s;
        case (f3)
          F3_0:    result.operation_code = OP_SB;
          F3_1:    result.operation_code = OP_SH;
          F3_2:    result.operation_code = OP_SW;
          default: result.operation_code = OP_UNKNOWN;
        endcase
      end
      OPC_BRANCH: begin
        result.format_class = FMT_SB;
        result.immediate    = imm_b;
        case (f3)
          F3_0:    result.operation_code = OP_BEQ;
          F3_1:    result.operation_code = OP_BNE;
          F3_4:    result.operation_code = OP_BLT;
          F3_5:    result.operation_code = OP_BGE;
          default: result.operation_code = OP_UNKNOWN;
        endcase
      end
      OPC_LUI: begin
        result.format_class   = FMT_U;
        result.immediate      = imm_u;
        result.operation_code = OP_LUI;
      end
      OPC_AUIPC: begin
        result.format_class   = FMT_U;
        result.immediate      = imm_u;
        result.operation_code = OP_AUIPC;
      end
      OPC_JAL: begin
        result.format_class   = FMT_UJ;
        result.immediate      = imm_j;
        result.operation_code = OP_JAL;
      end
      default: begin
        result.format_class   = FMT_UNKNOWN;
        result.operation_code = OP_UNKNOWN;
        result.immediate      = '0;
      end
    endcase
  end

endmodule

@@ rtl/rv32i_instruction_decoder.sv @@
// RV32I instruction decoder: input register, one pass of decode logic,
// result register. Depends on rvdec_pkg and rvdec_core.
// Path: each beat goes through the input register, then the result register;
// throughput 1 beat/cycle while out_stall is low.
// A stall on the result side holds the result register; the input register
// takes a beat while it is empty or the result register can take one, so
// in_stall rises in the same cycle as out_stall once both stages are full.
// Reset (rst, synchronous, active high) empties both stages.
module rv32i_instruction_decoder
  import rvdec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instr_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         opcode_field,
  output logic [2:0]         format_class,
  output logic [5:0]         operation_code,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic [2:0]         func3_field,
  output logic [6:0]         func7_field,
  output logic signed [31:0] immediate
);

  logic        word_valid;
  logic [31:0] word;
  logic        res_ready;
  logic        word_ready;
  dec_result_t dec;
  dec_result_t res;

  // Each stage moves when the one after it can take a beat
  assign res_ready  = !out_valid || !out_stall;
  assign word_ready = !word_valid || res_ready;
  assign in_stall   = !word_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (word_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && word_ready) begin
      word <= instr_word;
    end
  end

  rvdec_core u_core (
    .word   (word),
    .result (dec)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && res_ready) begin
      res <= dec;
    end
  end

  // Drive the result ports
  assign opcode_field   = res.opcode_field;
  assign format_class   = res.format_class;
  assign operation_code = res.operation_code;
  assign dest_reg       = res.dest_reg;
  assign src1_reg       = res.src1_reg;
  assign src2_reg       = res.src2_reg;
  assign func3_field    = res.func3_field;
  assign func7_field    = res.func7_field;
  assign immediate      = $signed(res.immediate);

endmodule

@@ rtl/rvdec_checker.sv @@
// Port-level checks for the RV32I decoder, bound to the top level.
// Depends on rvdec_pkg and rv32i_instruction_decoder.
module rvdec_checker
  import rvdec_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [6:0]         opcode_field,
  input logic [2:0]         format_class,
  input logic [5:0]         operation_code,
  input logic [4:0]         dest_reg,
  input logic signed [31:0] immediate
);

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(opcode_field)
      && $stable(operation_code) && $stable(immediate) && $stable(dest_reg))
    else $error("stalled result beat changed");

  // Unknown opcodes give no operation and no immediate
  a_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_class == FMT_UNKNOWN |->
      operation_code == OP_UNKNOWN && immediate == 0)
    else $error("unknown format with operation or immediate");

  // R-type carries its own opcode and a zero immediate
  a_rtype: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_class == FMT_R |-> opcode_field == OPC_R && immediate == 0)
    else $error("R-type result inconsistent");

  // Upper immediates have clear low bits
  a_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_class == FMT_U |-> immediate[11:0] == 12'd0
      && (operation_code == OP_LUI || operation_code == OP_AUIPC))
    else $error("U-type result inconsistent");

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (.*);
